@@ hdl/amr_rdf_pkg.sv @@
// Shared types, constants and helper functions of the AMR RTP payload deframer.
package amr_rdf_pkg;

  // Configuration register indexes.
  localparam logic REG_OCTET_ALIGNED = 1'b0;
  localparam logic REG_ALLOWED_MODES = 1'b1;

  // Result item kinds.
  localparam logic KIND_SPEECH = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Packet outcome codes.
  localparam logic [1:0] OUTC_OK    = 2'd0;
  localparam logic [1:0] OUTC_SHORT = 2'd1;
  localparam logic [1:0] OUTC_HDR   = 2'd2;
  localparam logic [1:0] OUTC_LEN   = 2'd3;

  // Header bit masks.
  localparam logic [7:0] OA_TOC_MASK  = 8'hC4;  // F bit, top frame-type bit and Q bit of the octet-aligned TOC
  localparam logic [7:0] OA_TOC_VALUE = 8'h04;  // F clear, top frame-type bit clear, Q set
  localparam logic [7:0] BE_F_MASK    = 8'h0C;  // F bit and top frame-type bit in byte 0
  localparam logic [7:0] BE_Q_MASK    = 8'h40;  // Q bit in byte 1
  localparam logic [2:0] FT_MASK      = 3'h7;

  // Number of class bits in each AMR frame type.
  localparam logic [7:0] FRAME_BITS [8] = '{
    8'd95, 8'd103, 8'd118, 8'd134, 8'd148, 8'd159, 8'd204, 8'd244
  };

  // Header overhead in bits for each layout.
  localparam logic [8:0] OA_HDR_BITS = 9'd16;
  localparam logic [8:0] BE_HDR_BITS = 9'd10;

  localparam logic [5:0] POS_MAX = 6'd63;

  // Queue depth and its pointer width.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One result item.
  typedef struct packed {
    logic       item_kind;
    logic [7:0] speech_byte;
    logic [2:0] frame_kind;
    logic [1:0] outcome;
    logic [2:0] active_mode;
    logic       run_end;
  } item_t;

  // Up to three compacted result items written to the queue at once.
  typedef struct packed {
    logic [1:0]      count;
    item_t [2:0]     items;
  } push_t;

  // Payload length in bytes for a frame type and a header size.
  function automatic logic [5:0] exp_bytes(input logic [2:0] ft, input logic [8:0] hdr);
    logic [8:0] total;
    total = hdr + {1'b0, FRAME_BITS[ft]} + 9'd7;
    return total[8:3];
  endfunction

  // Highest set bit of mask at or below limit; found is low when there is none.
  function automatic logic [3:0] highest_allowed(input logic [7:0] mask,
                                                 input logic [2:0] limit);
    logic       found;
    logic [2:0] idx;
    found = 1'b0;
    idx   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mask[i] && (3'(i) <= limit)) begin
        found = 1'b1;
        idx   = 3'(i);
      end
    end
    return {found, idx};
  endfunction

endpackage

@@ hdl/amr_rdf_parse.sv @@
// Input register, header parsing, length checks and mode-request handling.
module amr_rdf_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          payload_byte_i,
  input  logic                end_of_packet_i,
  input  logic                space_ok_i,
  output amr_rdf_pkg::push_t  push_o
);
  import amr_rdf_pkg::*;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Configuration and per-packet state.
  logic       oa_q, oa_d;
  logic [7:0] allowed_q, allowed_d;
  logic [2:0] mode_q, mode_d;
  logic [5:0] pos_q, pos_d;
  logic [7:0] held_q, held_d;
  logic [3:0] req_q, req_d;
  logic [2:0] ht_q, ht_d;
  logic [5:0] len_q, len_d;
  logic [1:0] err_q, err_d;

  logic       advance;
  logic       sp_en, fl_en;
  logic [7:0] sp_byte;
  logic [2:0] ft;
  logic [1:0] oc;
  logic [3:0] hit;
  item_t      sp_item, fl_item, st_item;

  assign advance    = in_vld_q && space_ok_i;
  assign in_ready_o = !in_vld_q || advance;

  // Processing of the registered byte against the packet state.
  always_comb begin
    oa_d      = oa_q;
    allowed_d = allowed_q;
    mode_d    = mode_q;
    pos_d     = pos_q;
    held_d    = held_q;
    req_d     = req_q;
    ht_d      = ht_q;
    len_d     = len_q;
    err_d     = err_q;
    sp_en     = 1'b0;
    fl_en     = 1'b0;
    sp_byte   = 8'd0;
    ft        = 3'd0;
    oc        = OUTC_OK;
    hit       = 4'd0;
    sp_item   = '0;
    fl_item   = '0;
    st_item   = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OCTET_ALIGNED: oa_d = cfg_data_i[0];
        REG_ALLOWED_MODES: begin
          allowed_d = cfg_data_i;
          hit       = highest_allowed(cfg_data_i, 3'd7);
          if (hit[3]) mode_d = hit[2:0];
        end
        default: ;
      endcase
    end

    if (advance) begin
      if (pos_q == 6'd0) begin
        req_d  = in_byte_q[7:4];
        ht_d   = 3'd0;
        if (!oa_q && ((in_byte_q & BE_F_MASK) != 8'd0)) err_d = OUTC_HDR;
        held_d = in_byte_q;
      end else if (pos_q == 6'd1) begin
        if (oa_q) begin
          ft = in_byte_q[5:3];
          if (((in_byte_q & OA_TOC_MASK) != OA_TOC_VALUE) && (err_q == OUTC_OK))
            err_d = OUTC_HDR;
          len_d = exp_bytes(ft, OA_HDR_BITS);
        end else begin
          ft = {held_q[1:0], in_byte_q[7]} & FT_MASK;
          if (((in_byte_q & BE_Q_MASK) == 8'd0) && (err_q == OUTC_OK))
            err_d = OUTC_HDR;
          len_d = exp_bytes(ft, BE_HDR_BITS);
        end
        ht_d   = ft;
        held_d = in_byte_q;
      end else if (err_q == OUTC_OK) begin
        if (pos_q < len_q) begin
          sp_en   = 1'b1;
          sp_byte = oa_q ? in_byte_q : {held_q[5:0], in_byte_q[7:6]};
          held_d  = in_byte_q;
        end else begin
          err_d = OUTC_LEN;
        end
      end

      if (pos_q < POS_MAX) pos_d = pos_q + 6'd1;

      // Speech item carries the mode in force before any update.
      sp_item.item_kind   = KIND_SPEECH;
      sp_item.speech_byte = sp_byte;
      sp_item.frame_kind  = ht_d;
      sp_item.outcome     = OUTC_OK;
      sp_item.active_mode = mode_q;
      sp_item.run_end     = !in_last_q;

      if (in_last_q) begin
        if (pos_d < 6'd2)          oc = OUTC_SHORT;
        else if (err_d != OUTC_OK) oc = err_d;
        else if (pos_d != len_d)   oc = OUTC_LEN;
        else                       oc = OUTC_OK;

        fl_item.item_kind   = KIND_SPEECH;
        fl_item.speech_byte = {held_d[5:0], 2'b00};
        fl_item.frame_kind  = ht_d;
        fl_item.outcome     = OUTC_OK;
        fl_item.active_mode = mode_q;
        fl_item.run_end     = 1'b0;

        if (oc == OUTC_OK) begin
          fl_en = !oa_q;
          if (!req_d[3] && (req_d[2:0] != mode_q)) begin
            hit = highest_allowed(allowed_q, req_d[2:0]);
            if (hit[3]) mode_d = hit[2:0];
          end
        end

        st_item.item_kind   = KIND_STATUS;
        st_item.speech_byte = 8'd0;
        st_item.frame_kind  = (oc == OUTC_SHORT) ? 3'd0 : ht_d;
        st_item.outcome     = oc;
        st_item.active_mode = mode_d;
        st_item.run_end     = 1'b1;

        // Per-packet state returns to its reset value.
        pos_d  = 6'd0;
        held_d = 8'd0;
        req_d  = 4'd0;
        ht_d   = 3'd0;
        len_d  = 6'd0;
        err_d  = OUTC_OK;
      end
    end
  end

  // Compact the speech, flush and status items into consecutive slots.
  always_comb begin
    push_o.count    = 2'd0;
    push_o.items[2] = st_item;
    push_o.items[1] = st_item;
    push_o.items[0] = st_item;
    if (advance) begin
      push_o.count = {1'b0, sp_en} + {1'b0, fl_en} + {1'b0, in_last_q};
    end
    if (sp_en) begin
      push_o.items[0] = sp_item;
      push_o.items[1] = fl_en ? fl_item : st_item;
    end else if (fl_en) begin
      push_o.items[0] = fl_item;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= payload_byte_i;
      in_last_q <= end_of_packet_i;
    end
  end

  // Configuration and packet state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oa_q      <= 1'b0;
      allowed_q <= 8'hFF;
      mode_q    <= 3'd7;
      pos_q     <= 6'd0;
      held_q    <= 8'd0;
      req_q     <= 4'd0;
      ht_q      <= 3'd0;
      len_q     <= 6'd0;
      err_q     <= OUTC_OK;
    end else begin
      oa_q      <= oa_d;
      allowed_q <= allowed_d;
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      held_q    <= held_d;
      req_q     <= req_d;
      ht_q      <= ht_d;
      len_q     <= len_d;
      err_q     <= err_d;
    end
  end

endmodule

@@ hdl/amr_rdf_outq.sv @@
// Result queue: takes up to three items per cycle and delivers one per transaction.
module amr_rdf_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  amr_rdf_pkg::push_t  push_i,
  output logic                space_ok_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output amr_rdf_pkg::item_t  item_o
);
  import amr_rdf_pkg::*;

  item_t           mem_q [QDEPTH];
  logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QAW:0]    cnt_q;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign item_o      = mem_q[rd_ptr_q];
  // Room for the largest burst of three items.
  assign space_ok_o  = (cnt_q <= (QAW+1)'(QDEPTH - 3));

  // Storage writes.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_i.count) begin
        mem_q[wr_ptr_q + QAW'(k)] <= push_i.items[k];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QAW'(push_i.count);
      if (pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
      cnt_q <= cnt_q + (QAW+1)'(push_i.count) - (QAW+1)'(pop);
    end
  end

endmodule

@@ hdl/amr_rtp_payload_deframer.sv @@
// Top level of the single-frame AMR RTP payload deframer.
// The block takes one payload byte per cycle while its output queue has room, and
// turns each packet into realigned speech bytes followed by one status item; a byte
// is held in an input register and parsed from there once the queue has room for
// its results, which land in a four-entry output queue. A middle byte gives at most
// one result and the stream runs at one byte per cycle while the output is ready;
// the final byte of a packet gives up to three (speech byte, bandwidth-efficient
// flush, status), which the queue drains one per cycle while the output is ready,
// and input holds off until there is room again. The user must write configuration
// through cfg_we_i, cfg_idx_i and cfg_data_i only while no packet is in flight; the
// block does not enforce it. Writing a non-empty allowed-mode set reloads the mode.
module amr_rtp_payload_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  input  logic       end_of_packet_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       item_kind_o,
  output logic [7:0] speech_byte_o,
  output logic [2:0] frame_kind_o,
  output logic [1:0] outcome_o,
  output logic [2:0] active_mode_o,
  output logic       run_end_o
);
  import amr_rdf_pkg::*;

  push_t push;
  logic  space_ok;
  item_t item;

  // Parsing stage.
  amr_rdf_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .payload_byte_i  (payload_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .space_ok_i      (space_ok),
    .push_o          (push)
  );

  // Result queue.
  amr_rdf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (item)
  );

  assign item_kind_o   = item.item_kind;
  assign speech_byte_o = item.speech_byte;
  assign frame_kind_o  = item.frame_kind;
  assign outcome_o     = item.outcome;
  assign active_mode_o = item.active_mode;
  assign run_end_o     = item.run_end;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the AMR RTP payload deframer with its own deframing predictor.
module testbench;
  import amr_rdf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  // Class bits per AMR frame type and the header bits the block checks.
  localparam int SPEECH_BITS [8] = '{95, 103, 118, 134, 148, 159, 204, 244};
  localparam logic [7:0] TOC_CHECK_MASK = 8'hC4;
  localparam logic [7:0] TOC_GOOD_BITS  = 8'h04;
  localparam logic [7:0] BE_ZERO_MASK   = 8'h0C;
  localparam logic [7:0] BE_Q_BIT       = 8'h40;
  localparam int POS_LIMIT = 63;

  typedef enum int {
    PKT_GOOD, PKT_BAD_LEN, PKT_BAD_HDR, PKT_NOISE, PKT_OVERLONG
  } pkt_flavor_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } payload_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = 8'd0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] payload_byte_i = 8'd0;
  logic       end_of_packet_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       item_kind_o;
  logic [7:0] speech_byte_o;
  logic [2:0] frame_kind_o;
  logic [1:0] outcome_o;
  logic [2:0] active_mode_o;
  logic       run_end_o;

  amr_rtp_payload_deframer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .payload_byte_i (payload_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .item_kind_o    (item_kind_o),
    .speech_byte_o  (speech_byte_o),
    .frame_kind_o   (frame_kind_o),
    .outcome_o      (outcome_o),
    .active_mode_o  (active_mode_o),
    .run_end_o      (run_end_o)
  );

  // Predictor copy of the configuration and of the deframing state.
  logic       oa_mode = 1'b0;
  logic [7:0] mode_mask = 8'hFF;
  logic [2:0] tx_mode = 3'd7;
  logic [5:0] byte_pos = 6'd0;
  logic [7:0] prev_byte = 8'd0;
  logic [3:0] cmr_nibble = 4'd0;
  logic [2:0] toc_type = 3'd0;
  logic [5:0] frame_len = 6'd0;
  logic [1:0] pkt_error = 2'd0;

  payload_t payload_q [$];
  item_t    deframed_q [$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       in_pauses = 1'b0;
  bit       out_pauses = 1'b0;

  int       in_gap = 0;
  int       out_stall = 0;
  payload_t next_byte;
  logic     in_busy;
  item_t    got_item;
  item_t    want_item;
  logic     field_diff;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Random gap length: mostly none or short, now and then long.
  function automatic int pause_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // One result item built from the current header type and transmit mode.
  function automatic item_t make_item(input logic kind, input logic [7:0] sb,
                                      input logic [1:0] oc);
    item_t it;
    it.item_kind   = kind;
    it.speech_byte = sb;
    it.frame_kind  = toc_type;
    it.outcome     = oc;
    it.active_mode = tx_mode;
    it.run_end     = 1'b0;
    return it;
  endfunction

  // Deframing prediction for one accepted payload byte.
  function automatic void deframe_byte(input logic [7:0] b, input logic last);
    item_t      res [3];
    int         n;
    logic [2:0] ft;
    logic [1:0] oc;
    logic [7:0] sb;
    bit         found;
    n = 0;
    if (byte_pos == 6'd0) begin
      cmr_nibble = b[7:4];
      toc_type = 3'd0;
      if (!oa_mode && (b & BE_ZERO_MASK) != 8'd0) pkt_error = OUTC_HDR;
      prev_byte = b;
    end else if (byte_pos == 6'd1) begin
      if (oa_mode) begin
        ft = b[5:3];
        if ((b & TOC_CHECK_MASK) != TOC_GOOD_BITS && pkt_error == OUTC_OK)
          pkt_error = OUTC_HDR;
        frame_len = 6'((16 + SPEECH_BITS[ft] + 7) / 8);
      end else begin
        ft = {prev_byte[1:0], b[7]};
        if ((b & BE_Q_BIT) == 8'd0 && pkt_error == OUTC_OK) pkt_error = OUTC_HDR;
        frame_len = 6'((10 + SPEECH_BITS[ft] + 7) / 8);
      end
      toc_type = ft;
      prev_byte = b;
    end else if (pkt_error == OUTC_OK) begin
      if (byte_pos < frame_len) begin
        sb = oa_mode ? b : {prev_byte[5:0], b[7:6]};
        res[n] = make_item(KIND_SPEECH, sb, OUTC_OK);
        n++;
        prev_byte = b;
      end else begin
        pkt_error = OUTC_LEN;
      end
    end

    if (byte_pos < 6'(POS_LIMIT)) byte_pos++;

    // Closing status, with the bandwidth-efficient flush and the mode update on success.
    if (last) begin
      if (byte_pos < 6'd2) oc = OUTC_SHORT;
      else if (pkt_error != OUTC_OK) oc = pkt_error;
      else if (byte_pos != frame_len) oc = OUTC_LEN;
      else oc = OUTC_OK;
      if (oc == OUTC_OK) begin
        if (!oa_mode) begin
          res[n] = make_item(KIND_SPEECH, {prev_byte[5:0], 2'b00}, OUTC_OK);
          n++;
        end
        if (cmr_nibble < 4'd8 && cmr_nibble[2:0] != tx_mode) begin
          found = 1'b0;
          for (int i = 7; i >= 0; i--) begin
            if (!found && i <= int'(cmr_nibble) && mode_mask[i]) begin
              tx_mode = 3'(i);
              found = 1'b1;
            end
          end
        end
      end
      if (oc == OUTC_SHORT) toc_type = 3'd0;
      res[n] = make_item(KIND_STATUS, 8'd0, oc);
      n++;
      byte_pos = 6'd0;
      prev_byte = 8'd0;
      cmr_nibble = 4'd0;
      toc_type = 3'd0;
      frame_len = 6'd0;
      pkt_error = OUTC_OK;
    end

    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].run_end = 1'b1;
      deframed_q.push_back(res[i]);
    end
  endfunction

  // Register write, mirrored in the predictor; an empty mode set leaves the mode alone.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    bit found;
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == REG_OCTET_ALIGNED) begin
      oa_mode = value[0];
    end else begin
      mode_mask = value;
      found = 1'b0;
      for (int i = 7; i >= 0; i--) begin
        if (!found && value[i]) begin
          tx_mode = 3'(i);
          found = 1'b1;
        end
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    payload_q.push_back('{data, last});
  endtask

  // Wait until every byte is taken and every predicted item has come out, then settle.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (payload_q.size() != 0 || in_valid_i || deframed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Builds one packet for the current layout; returns the number of bytes queued.
  task automatic queue_packet(input pkt_flavor_e flavor, output int counted);
    logic [7:0] bytes [$];
    logic [2:0] ft;
    logic [3:0] cmr;
    int         len;
    ft  = 3'($urandom_range(0, 7));
    cmr = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    if (oa_mode) begin
      bytes.push_back({cmr, 4'($urandom)});
      bytes.push_back({2'b00, ft, 1'b1, 2'($urandom)});
      len = (16 + SPEECH_BITS[ft] + 7) / 8;
    end else begin
      bytes.push_back({cmr, 2'b00, ft[2:1]});
      bytes.push_back({ft[0], 1'b1, 6'($urandom)});
      len = (10 + SPEECH_BITS[ft] + 7) / 8;
    end
    case (flavor)
      PKT_BAD_LEN: begin
        if ($urandom_range(0, 1) == 1) len = len + $urandom_range(1, 3);
        else len = len - $urandom_range(1, 3);
      end
      PKT_BAD_HDR: begin
        if (oa_mode) begin
          case ($urandom_range(0, 2))
            0: bytes[1] = bytes[1] ^ 8'h80;
            1: bytes[1] = bytes[1] ^ 8'h40;
            default: bytes[1] = bytes[1] ^ 8'h04;
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0: bytes[0] = bytes[0] ^ 8'h08;
            1: bytes[0] = bytes[0] ^ 8'h04;
            default: bytes[1] = bytes[1] ^ BE_Q_BIT;
          endcase
        end
      end
      PKT_NOISE: begin
        bytes.delete();
        len = $urandom_range(1, 6);
      end
      PKT_OVERLONG: begin
        len = $urandom_range(64, 70);
      end
      default: ;
    endcase
    counted = len;
    while (bytes.size() > len) void'(bytes.pop_back());
    while (bytes.size() < len) bytes.push_back(8'($urandom));
    for (int i = 0; i < len; i++) push_byte(bytes[i], i == len - 1);
  endtask

  // Input driver: presents queued payload bytes with random gaps between transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      payload_byte_i  <= 8'd0;
      end_of_packet_i <= 1'b0;
      in_gap          <= 0;
    end else begin
      in_busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        deframe_byte(payload_byte_i, end_of_packet_i);
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (payload_q.size() != 0) begin
          next_byte = payload_q.pop_front();
          payload_byte_i  <= next_byte.data;
          end_of_packet_i <= next_byte.last;
          in_valid_i      <= 1'b1;
          in_gap          <= pause_len(in_pauses);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_item = '{item_kind_o, speech_byte_o, frame_kind_o, outcome_o,
                     active_mode_o, run_end_o};
        if (deframed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result kind %0d byte %02h type %0d",
                     $time, got_item.item_kind, got_item.speech_byte,
                     got_item.frame_kind,
                     " outcome %0d mode %0d end %0d",
                     got_item.outcome, got_item.active_mode, got_item.run_end);
        end else begin
          want_item = deframed_q.pop_front();
          field_diff = (got_item.item_kind   !== want_item.item_kind)   ||
                       (got_item.speech_byte !== want_item.speech_byte) ||
                       (got_item.frame_kind  !== want_item.frame_kind)  ||
                       (got_item.outcome     !== want_item.outcome)     ||
                       (got_item.active_mode !== want_item.active_mode) ||
                       (got_item.run_end     !== want_item.run_end);
          if (field_diff) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch (expected/actual) kind %0d/%0d byte %02h/%02h",
                       $time, want_item.item_kind, got_item.item_kind,
                       want_item.speech_byte, got_item.speech_byte,
                       " type %0d/%0d outcome %0d/%0d",
                       want_item.frame_kind, got_item.frame_kind,
                       want_item.outcome, got_item.outcome,
                       " mode %0d/%0d end %0d/%0d",
                       want_item.active_mode, got_item.active_mode,
                       want_item.run_end, got_item.run_end);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall   <= out_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 7) == 0) out_stall <= pause_len(out_pauses);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus sequence: directed corner packets, then random packets under several settings.
  initial begin
    logic [7:0] mask_pick;
    int         budget;
    int         got_bytes;
    int         r;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bandwidth-efficient corner packets.
    write_reg(REG_OCTET_ALIGNED, 8'd0);
    write_reg(REG_ALLOWED_MODES, 8'hFF);
    push_byte(8'hFF, 1'b1);                        // one byte only, header bits bad too
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1); // Q bit clear
    push_byte(8'h0C, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b1);
    push_byte(8'h70, 1'b0); push_byte(8'h40, 1'b0); push_byte(8'hAA, 1'b1); // too short
    wait_drained();

    // Octet-aligned corner packets, ending with a packet left open.
    write_reg(REG_OCTET_ALIGNED, 8'd1);
    push_byte(8'hF0, 1'b0); push_byte(8'h3C, 1'b0); push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
    push_byte(8'h30, 1'b0); push_byte(8'h04, 1'b0);
    wait_drained();

    // The layout flips in the middle of the open packet.
    write_reg(REG_OCTET_ALIGNED, 8'd0);
    push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b1);
    wait_drained();

    // Random phases: mode sets at the extremes and in between, gaps on or off per side.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: mask_pick = 8'hFF;
        1: mask_pick = 8'h00;
        2: mask_pick = 8'h01;
        3: mask_pick = 8'h80;
        default: mask_pick = 8'($urandom);
      endcase
      write_reg(REG_ALLOWED_MODES, mask_pick);
      write_reg(REG_OCTET_ALIGNED, (phase < 2) ? 8'(phase) : 8'($urandom_range(0, 1)));
      in_pauses  = ($urandom_range(0, 3) != 0);
      out_pauses = ($urandom_range(0, 3) != 0);
      budget = 0;
      if (phase == 2) begin
        queue_packet(PKT_OVERLONG, got_bytes);
        budget += got_bytes;
      end
      while (budget < 12) begin
        r = $urandom_range(0, 99);
        if (r < 65) queue_packet(PKT_GOOD, got_bytes);
        else if (r < 78) queue_packet(PKT_BAD_LEN, got_bytes);
        else if (r < 88) queue_packet(PKT_BAD_HDR, got_bytes);
        else if (r < 97) queue_packet(PKT_NOISE, got_bytes);
        else queue_packet(PKT_OVERLONG, got_bytes);
        budget += got_bytes;
      end
      wait_drained();
    end

    if (deframed_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/amr_rdf_pkg.sv
hdl/amr_rdf_parse.sv
hdl/amr_rdf_outq.sv
hdl/amr_rtp_payload_deframer.sv
verif/testbench.sv
